// ===== hw/rtl/tbs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and codes for the bilinear texture sampler
// no dependencies

package tbs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int XIDX_W     = $clog2(MAX_WIDTH);
   localparam int YIDX_W     = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 9;
   localparam int TEXEL_W    = 32;
   localparam int CH_W       = 16;
   localparam int MOD_W      = 26;
   localparam int SCALE_W    = 42;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val,
                                                  input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] r;
      if (reg_val == '0) r = SIZE_W'(1);
      else if (reg_val > limit) r = limit;
      else r = reg_val;
      return r;
   endfunction

endpackage

// ===== hw/rtl/tbs_req_if.sv =====
`timescale 1ns / 1ps
// request channel: valid/ready plus action and coordinates
// depends on tbs_pkg

interface tbs_req_if;
   import tbs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic signed [15:0]        coord_x;
   logic signed [15:0]        coord_y;
   logic [TEXEL_W-1:0]        write_texel;
   logic signed [31:0]        tex_u;
   logic signed [31:0]        tex_v;

   modport source (output valid, action, coord_x, coord_y, write_texel, tex_u, tex_v,
                   input ready);
   modport sink   (input valid, action, coord_x, coord_y, write_texel, tex_u, tex_v,
                   output ready);
endinterface

// ===== hw/rtl/tbs_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel: valid/ready plus four filtered channels
// depends on tbs_pkg

interface tbs_rsp_if;
   import tbs_pkg::*;
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  red_out;
   logic [CH_W-1:0]  green_out;
   logic [CH_W-1:0]  blue_out;
   logic [CH_W-1:0]  alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== hw/rtl/tbs_ram.sv =====
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies

module tbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/tbs_mod_unit.sv =====
`timescale 1ns / 1ps
// repeat-wrap unit: signed value modulo a small size, one quotient bit per cycle
// depends on tbs_pkg

module tbs_mod_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tbs_pkg::MOD_W-1:0]    value,
   input  logic [tbs_pkg::SIZE_W-1:0]          modulus,
   output logic                                done,
   output logic [tbs_pkg::SIZE_W-1:0]          result
);
   import tbs_pkg::*;

   logic [MOD_W-1:0]          mag_ff, mag_in;
   logic [SIZE_W-1:0]         rem_ff, rem_in;
   logic [$clog2(MOD_W)-1:0]  cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [SIZE_W-1:0]         trial;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SIZE_W-2:0], mag_ff[MOD_W-1]};
      if (start) begin
         neg_in = value[MOD_W-1];
         mag_in = value[MOD_W-1] ? MOD_W'(-value) : MOD_W'(value);
         rem_in = '0;
         cnt_in = ($clog2(MOD_W))'(MOD_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (trial >= modulus) ? trial - modulus : trial;
         mag_in = {mag_ff[MOD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done   = done_ff;
   assign result = (neg_ff && rem_ff != '0) ? modulus - rem_ff : rem_ff;
endmodule

// ===== hw/rtl/bilinear_texture_sampler_wrap.sv =====
`timescale 1ns / 1ps
// bilinear texture sampler with repeat wrap: sequencer, shared multiplier, blend lanes
// depends on tbs_pkg, tbs_req_if, tbs_rsp_if, tbs_ram, tbs_mod_unit
// each item runs alone; the serial wrap unit sets the rate
// one result may wait in the output register while the next request is taken
// synchronous reset restores both size registers to 256; texel memory is not cleared

module bilinear_texture_sampler_wrap (
   input  logic                         clock,
   input  logic                         reset,
   tbs_req_if.sink                      req_chan,
   tbs_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [tbs_pkg::SIZE_W-1:0]   csr_wdata
);
   import tbs_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_SCALE_U = 14'b00000000000010,
      S_SCALE_V = 14'b00000000000100,
      S_MODX    = 14'b00000000001000,
      S_WAITX   = 14'b00000000010000,
      S_MODY    = 14'b00000000100000,
      S_WAITY   = 14'b00000001000000,
      S_ROW0    = 14'b00000010000000,
      S_ROW1    = 14'b00000100000000,
      S_FETCH   = 14'b00001000000000,
      S_CAPT    = 14'b00010000000000,
      S_LERP0   = 14'b00100000000000,
      S_LERP1   = 14'b01000000000000,
      S_DONE    = 14'b10000000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [SIZE_W-1:0]          width_ff, height_ff;
   logic [SIZE_W-1:0]          w_eff, h_eff;

   action_type                 act_ff;
   logic signed [15:0]         cx_ff, cy_ff;
   logic [TEXEL_W-1:0]         wt_ff;
   logic signed [31:0]         u_ff, v_ff;
   logic signed [SCALE_W-1:0]  su_ff, sv_ff;
   logic [XIDX_W-1:0]          x0_ff, x1;
   logic [YIDX_W-1:0]          y0_ff, y1;
   logic [15:0]                a_ff, b_ff;
   logic [ADDR_W-1:0]          row0_ff, row1_ff;
   logic [1:0]                 k_ff;
   logic [TEXEL_W-1:0]         tex_ff [4];
   logic [24:0]                r0_ff [4];
   logic [24:0]                r1_ff [4];
   logic [CH_W-1:0]            res_ff [4];
   logic [CH_W-1:0]            out_ff [4];
   logic                       rsp_valid_ff;

   logic signed [32:0]         mul_a;
   logic [SIZE_W-1:0]          mul_n;
   logic signed [SCALE_W-1:0]  prod;
   logic                       mod_start, mod_done;
   logic signed [MOD_W-1:0]    mod_val;
   logic [SIZE_W-1:0]          mod_n, mod_res;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_addr;
   logic [TEXEL_W-1:0]         ram_rdata;
   logic                       req_fire, rsp_fire, out_free;
   logic [16:0]                ia, ib;

   assign w_eff = eff_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign h_eff = eff_size(height_ff, SIZE_W'(MAX_HEIGHT));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // shared multiplier
   always_comb begin
      mul_a = 33'(signed'(u_ff));
      mul_n = w_eff;
      case (state_ff)
         S_SCALE_V: begin
            mul_a = 33'(signed'(v_ff));
            mul_n = h_eff;
         end
         S_ROW0:  mul_a = signed'({{(33-YIDX_W){1'b0}}, y0_ff});
         S_ROW1:  mul_a = signed'({{(33-YIDX_W){1'b0}}, y1});
         default: mul_a = 33'(signed'(u_ff));
      endcase
   end
   assign prod = SCALE_W'(mul_a * signed'({1'b0, mul_n}));

   assign x1 = (SIZE_W'(x0_ff) + 1'b1 == w_eff) ? '0 : x0_ff + 1'b1;
   assign y1 = (SIZE_W'(y0_ff) + 1'b1 == h_eff) ? '0 : y0_ff + 1'b1;

   assign mod_start = (state_ff == S_MODX) || (state_ff == S_MODY);
   assign mod_n     = (state_ff == S_MODX || state_ff == S_WAITX) ? w_eff : h_eff;
   always_comb begin
      if (state_ff == S_MODX)
         mod_val = (act_ff == ACT_SAMPLE) ? su_ff[SCALE_W-1:16] : MOD_W'(cx_ff);
      else
         mod_val = (act_ff == ACT_SAMPLE) ? sv_ff[SCALE_W-1:16] : MOD_W'(cy_ff);
   end

   tbs_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   (mod_val),
      .modulus (mod_n),
      .done    (mod_done),
      .result  (mod_res)
   );

   always_comb begin
      case (k_ff)
         2'd0:    ram_addr = row0_ff + ADDR_W'(x0_ff);
         2'd1:    ram_addr = row0_ff + ADDR_W'(x1);
         2'd2:    ram_addr = row1_ff + ADDR_W'(x0_ff);
         default: ram_addr = row1_ff + ADDR_W'(x1);
      endcase
   end
   assign ram_we = (state_ff == S_FETCH) && (act_ff == ACT_WRITE);

   tbs_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (wt_ff),
      .rdata (ram_rdata)
   );

   assign ia = 17'h10000 - 17'(a_ff);
   assign ib = 17'h10000 - 17'(b_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_WRITE, ACT_READ: state_in = S_MODX;
                  ACT_SAMPLE:          state_in = S_SCALE_U;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_SCALE_U: state_in = S_SCALE_V;
         S_SCALE_V: state_in = S_MODX;
         S_MODX:    state_in = S_WAITX;
         S_WAITX:   if (mod_done) state_in = S_MODY;
         S_MODY:    state_in = S_WAITY;
         S_WAITY:   if (mod_done) state_in = S_ROW0;
         S_ROW0:    state_in = (act_ff == ACT_SAMPLE) ? S_ROW1 : S_FETCH;
         S_ROW1:    state_in = S_FETCH;
         S_FETCH:   state_in = (act_ff == ACT_WRITE) ? S_DONE : S_CAPT;
         S_CAPT: begin
            if (act_ff == ACT_READ) state_in = S_DONE;
            else if (k_ff == 2'd3) state_in = S_LERP0;
            else state_in = S_FETCH;
         end
         S_LERP0:   state_in = S_LERP1;
         S_LERP1:   state_in = S_DONE;
         S_DONE:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= SIZE_W'(MAX_WIDTH);
         height_ff    <= SIZE_W'(MAX_HEIGHT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default:    width_ff  <= width_ff;
            endcase
         end
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_fire) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= action_type'(req_chan.action);
         cx_ff  <= req_chan.coord_x;
         cy_ff  <= req_chan.coord_y;
         wt_ff  <= req_chan.write_texel;
         u_ff   <= req_chan.tex_u;
         v_ff   <= req_chan.tex_v;
         k_ff   <= 2'd0;
         for (int c = 0; c < 4; c++) res_ff[c] <= '0;
      end
      if (state_ff == S_SCALE_U) su_ff <= prod - SCALE_W'(32768);
      if (state_ff == S_SCALE_V) sv_ff <= prod - SCALE_W'(32768);
      if (state_ff == S_WAITX && mod_done) begin
         x0_ff <= XIDX_W'(mod_res);
         a_ff  <= su_ff[15:0];
      end
      if (state_ff == S_WAITY && mod_done) begin
         y0_ff <= YIDX_W'(mod_res);
         b_ff  <= sv_ff[15:0];
      end
      if (state_ff == S_ROW0) row0_ff <= prod[ADDR_W-1:0];
      if (state_ff == S_ROW1) row1_ff <= prod[ADDR_W-1:0];
      if (state_ff == S_CAPT) begin
         tex_ff[k_ff] <= ram_rdata;
         k_ff         <= k_ff + 1'b1;
         if (act_ff == ACT_READ)
            for (int c = 0; c < 4; c++) res_ff[c] <= {ram_rdata[8*c +: 8], 8'h00};
      end
      // four channel lanes
      if (state_ff == S_LERP0) begin
         for (int c = 0; c < 4; c++) begin
            r0_ff[c] <= 25'(tex_ff[0][8*c +: 8] * ia) + 25'(tex_ff[1][8*c +: 8] * a_ff);
            r1_ff[c] <= 25'(tex_ff[2][8*c +: 8] * ia) + 25'(tex_ff[3][8*c +: 8] * a_ff);
         end
      end
      if (state_ff == S_LERP1) begin
         for (int c = 0; c < 4; c++)
            res_ff[c] <= CH_W'((43'(r0_ff[c] * ib) + 43'(r1_ff[c] * b_ff)
                               + 43'h800000) >> 24);
      end
      if (state_ff == S_DONE && out_free)
         for (int c = 0; c < 4; c++) out_ff[c] <= res_ff[c];
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = out_ff[0];
   assign rsp_chan.green_out = out_ff[1];
   assign rsp_chan.blue_out  = out_ff[2];
   assign rsp_chan.alpha_out = out_ff[3];

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request taken while an item is in flight");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done step");

   a_store_write_only: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (act_ff == ACT_WRITE) && !rsp_fire || (act_ff == ACT_WRITE))
      else $error("texel store written by a non-write item");

   a_wrap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAITX && mod_done) |-> (mod_res < w_eff))
      else $error("wrapped column out of range");
endmodule
